// ===== rtl/dsf_pkg.sv =====
// Shared widths, configuration register indexes and the side-data bundle
// of the damped spring force pipeline. No dependencies.
package dsf_pkg;

   localparam int FRAC_BITS = 16;

   localparam int IN_W    = 32;                  // one field of the input item
   localparam int D_W     = IN_W + 1;            // difference of two positions
   localparam int MAG_W   = IN_W;                // magnitude of a position difference
   localparam int SQ_W    = 2 * MAG_W + 2;       // dx^2 + dy^2
   localparam int SQR_W   = SQ_W + 1;            // square root residual
   localparam int ROOT_W  = SQ_W / 2;            // spring length
   localparam int Q_W     = FRAC_BITS + 1;       // magnitude of a unit component
   localparam int U_W     = Q_W + 1;             // signed unit component
   localparam int DREM_W  = ROOT_W + FRAC_BITS;  // divider residual
   localparam int EXT_W   = ROOT_W + 1;          // rest length minus length
   localparam int GAIN_W  = IN_W + 1;            // gain as a signed value
   localparam int PR_W    = D_W + U_W;           // velocity times unit component
   localparam int PJ_W    = PR_W - FRAC_BITS + 1;
   localparam int KP_W    = EXT_W + GAIN_W;
   localparam int KS_W    = KP_W - FRAC_BITS;
   localparam int DP_W    = PJ_W + GAIN_W;
   localparam int DS_W    = DP_W - FRAC_BITS;
   localparam int INR_W   = DS_W + 1;
   localparam int FP_W    = U_W + INR_W;
   localparam int FS_W    = FP_W - FRAC_BITS;
   localparam int MIN_W   = 16;

   typedef enum logic [1:0] {
      CSR_STIFFNESS    = 2'd0,
      CSR_DAMPING_GAIN = 2'd1,
      CSR_MIN_DISTANCE = 2'd2
   } csr_index_type;

   // Data that rides beside the length and division pipelines.
   typedef struct packed {
      logic                  sx;
      logic                  sy;
      logic [MAG_W-1:0]      magx;
      logic [MAG_W-1:0]      magy;
      logic signed [D_W-1:0] rvx;
      logic signed [D_W-1:0] rvy;
      logic [IN_W-1:0]       rest;
   } side_type;

endpackage

// ===== rtl/dsf_sqrt.sv =====
// Pipelined floor square root, one result bit per register stage.
// Depends on dsf_pkg for widths and the side-data bundle.
module dsf_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_vld,
   input  logic [dsf_pkg::SQ_W-1:0]     in_sq,
   input  dsf_pkg::side_type            in_side,
   output logic                         out_vld,
   output logic [dsf_pkg::ROOT_W-1:0]   out_root,
   output dsf_pkg::side_type            out_side
);
   import dsf_pkg::*;

   logic [SQR_W-1:0]  rem_w  [ROOT_W+1];
   logic [ROOT_W-1:0] root_w [ROOT_W+1];
   logic              vld_w  [ROOT_W+1];
   side_type          side_w [ROOT_W+1];

   assign rem_w[0]  = SQR_W'(in_sq);
   assign root_w[0] = '0;
   assign vld_w[0]  = in_vld;
   assign side_w[0] = in_side;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      localparam int B = ROOT_W - 1 - i;
      logic [SQR_W-1:0]  trial;
      logic              take;
      logic [SQR_W-1:0]  rem_ff, rem_in;
      logic [ROOT_W-1:0] root_ff, root_in;
      logic              vld_ff;
      side_type          side_ff;

      // Try setting bit B: (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B).
      always_comb begin
         trial   = (SQR_W'(root_w[i]) << (B + 1)) | (SQR_W'(1) << (2 * B));
         take    = rem_w[i] >= trial;
         rem_in  = take ? rem_w[i] - trial : rem_w[i];
         root_in = take ? root_w[i] | (ROOT_W'(1) << B) : root_w[i];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= vld_w[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            side_ff <= side_w[i];
         end
      end

      assign rem_w[i+1]  = rem_ff;
      assign root_w[i+1] = root_ff;
      assign vld_w[i+1]  = vld_ff;
      assign side_w[i+1] = side_ff;
   end

   assign out_vld  = vld_w[ROOT_W];
   assign out_root = root_w[ROOT_W];
   assign out_side = side_w[ROOT_W];

endmodule

// ===== rtl/dsf_div.sv =====
// Pipelined restoring divider for both unit-vector components, one quotient
// bit per stage and lane. Depends on dsf_pkg.
module dsf_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_vld,
   input  logic [dsf_pkg::ROOT_W-1:0]        in_len,
   input  logic                              in_close,
   input  dsf_pkg::side_type                 in_side,
   output logic                              out_vld,
   output logic [dsf_pkg::ROOT_W-1:0]        out_len,
   output logic                              out_close,
   output logic signed [dsf_pkg::U_W-1:0]    out_ux,
   output logic signed [dsf_pkg::U_W-1:0]    out_uy,
   output dsf_pkg::side_type                 out_side
);
   import dsf_pkg::*;

   logic [DREM_W-1:0] remx_w [Q_W+1];
   logic [DREM_W-1:0] remy_w [Q_W+1];
   logic [Q_W-1:0]    qx_w   [Q_W+1];
   logic [Q_W-1:0]    qy_w   [Q_W+1];
   logic [ROOT_W-1:0] len_w  [Q_W+1];
   logic              cls_w  [Q_W+1];
   logic              vld_w  [Q_W+1];
   side_type          side_w [Q_W+1];

   assign remx_w[0] = DREM_W'(in_side.magx) << FRAC_BITS;
   assign remy_w[0] = DREM_W'(in_side.magy) << FRAC_BITS;
   assign qx_w[0]   = '0;
   assign qy_w[0]   = '0;
   assign len_w[0]  = in_len;
   assign cls_w[0]  = in_close;
   assign vld_w[0]  = in_vld;
   assign side_w[0] = in_side;

   for (genvar i = 0; i < Q_W; i++) begin : g_stage
      localparam int B = Q_W - 1 - i;
      logic [DREM_W-1:0] dvs;
      logic              tx, ty;
      logic [DREM_W-1:0] remx_ff, remy_ff;
      logic [Q_W-1:0]    qx_ff, qy_ff;
      logic [ROOT_W-1:0] len_ff;
      logic              cls_ff, vld_ff;
      side_type          side_ff;

      always_comb begin
         dvs = DREM_W'(len_w[i]) << B;
         tx  = remx_w[i] >= dvs;
         ty  = remy_w[i] >= dvs;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= vld_w[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            remx_ff <= tx ? remx_w[i] - dvs : remx_w[i];
            remy_ff <= ty ? remy_w[i] - dvs : remy_w[i];
            qx_ff   <= qx_w[i] | (Q_W'(tx) << B);
            qy_ff   <= qy_w[i] | (Q_W'(ty) << B);
            len_ff  <= len_w[i];
            cls_ff  <= cls_w[i];
            side_ff <= side_w[i];
         end
      end

      assign remx_w[i+1] = remx_ff;
      assign remy_w[i+1] = remy_ff;
      assign qx_w[i+1]   = qx_ff;
      assign qy_w[i+1]   = qy_ff;
      assign len_w[i+1]  = len_ff;
      assign cls_w[i+1]  = cls_ff;
      assign vld_w[i+1]  = vld_ff;
      assign side_w[i+1] = side_ff;
   end

   logic signed [U_W-1:0] ux_mag, uy_mag;
   assign ux_mag = $signed({1'b0, qx_w[Q_W]});
   assign uy_mag = $signed({1'b0, qy_w[Q_W]});

   assign out_vld   = vld_w[Q_W];
   assign out_len   = len_w[Q_W];
   assign out_close = cls_w[Q_W];
   assign out_side  = side_w[Q_W];
   assign out_ux    = side_w[Q_W].sx ? -ux_mag : ux_mag;
   assign out_uy    = side_w[Q_W].sy ? -uy_mag : uy_mag;

endmodule

// ===== rtl/damped_spring_force_2d.sv =====
// Damped Hookean spring force in 2D, Q16.16: top level with the input and
// product stages; instantiates dsf_sqrt and dsf_div, uses dsf_pkg.
// Springs pass the input stages, the 33-stage square root, the 17-stage divider
// and the product stages; one spring is accepted every cycle the pipe advances.
// The whole pipeline advances whenever the result register is empty or taken.
// Reset is synchronous and active high: it clears all valid bits and loads the
// register defaults (stiffness 1.0, damping 0, minimum distance 1 LSB).
module damped_spring_force_2d (
   input  logic         clock,
   input  logic         reset,
   // Spring input: pos_a_x, pos_a_y, vel_a_x, vel_a_y, pos_b_x, pos_b_y,
   // vel_b_x, vel_b_y, rest_length, 32 bits each, from the lowest bit up.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [287:0] req_tdata,
   // Force result: force_x, force_y, 32 bits each, from the lowest bit up.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,
   // Result flags: too_close (bit 0), saturated (bit 1).
   output logic [1:0]   rsp_tuser,
   // Register write port: stiffness, damping_gain, min_distance.
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);
   import dsf_pkg::*;

   // Configuration registers.
   logic [IN_W-1:0]  stiff_ff, damp_ff;
   logic [MIN_W-1:0] min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff <= IN_W'(65536);
         damp_ff  <= '0;
         min_ff   <= MIN_W'(1);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_STIFFNESS:    stiff_ff <= csr_wdata;
            CSR_DAMPING_GAIN: damp_ff  <= csr_wdata;
            CSR_MIN_DISTANCE: min_ff   <= csr_wdata[MIN_W-1:0];
            default:          ;
         endcase
      end
   end

   // Every stage moves together; a stall at the result holds them all.
   logic adv;
   logic rsp_vld_ff;
   assign adv        = !rsp_vld_ff || rsp_tready;
   assign req_tready = adv;

   // Stage 0: differences of positions and velocities.
   logic signed [D_W-1:0] dx_ff, dy_ff, rvx_ff, rvy_ff;
   logic [IN_W-1:0]       rest_ff;
   logic                  v0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff   <= D_W'($signed(req_tdata[31:0]))    - D_W'($signed(req_tdata[159:128]));
         dy_ff   <= D_W'($signed(req_tdata[63:32]))   - D_W'($signed(req_tdata[191:160]));
         rvx_ff  <= D_W'($signed(req_tdata[95:64]))   - D_W'($signed(req_tdata[223:192]));
         rvy_ff  <= D_W'($signed(req_tdata[127:96]))  - D_W'($signed(req_tdata[255:224]));
         rest_ff <= req_tdata[287:256];
      end
   end

   // Stage 1: squared length, with signs and magnitudes for the divider.
   logic [MAG_W-1:0] magx_c, magy_c;
   logic [SQ_W-1:0]  sq_ff;
   side_type         side1_ff;
   logic             v1_ff;

   assign magx_c = MAG_W'(dx_ff[D_W-1] ? -dx_ff : dx_ff);
   assign magy_c = MAG_W'(dy_ff[D_W-1] ? -dy_ff : dy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff         <= SQ_W'(magx_c * magx_c) + SQ_W'(magy_c * magy_c);
         side1_ff.sx   <= dx_ff[D_W-1];
         side1_ff.sy   <= dy_ff[D_W-1];
         side1_ff.magx <= magx_c;
         side1_ff.magy <= magy_c;
         side1_ff.rvx  <= rvx_ff;
         side1_ff.rvy  <= rvy_ff;
         side1_ff.rest <= rest_ff;
      end
   end

   // Length by square root, then the minimum-distance test feeding the divider.
   logic              sq_vld;
   logic [ROOT_W-1:0] len;
   side_type          sq_side;

   dsf_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (v1_ff),
      .in_sq    (sq_ff),
      .in_side  (side1_ff),
      .out_vld  (sq_vld),
      .out_root (len),
      .out_side (sq_side)
   );

   logic                  dv_vld, dv_close;
   logic [ROOT_W-1:0]     dv_len;
   logic signed [U_W-1:0] ux, uy;
   side_type              dv_side;

   dsf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_vld    (sq_vld),
      .in_len    (len),
      .in_close  (len <= ROOT_W'(min_ff)),
      .in_side   (sq_side),
      .out_vld   (dv_vld),
      .out_len   (dv_len),
      .out_close (dv_close),
      .out_ux    (ux),
      .out_uy    (uy),
      .out_side  (dv_side)
   );

   // Product stages. Each product is exact and then shifted arithmetically,
   // which rounds toward minus infinity.
   logic signed [EXT_W-1:0]  ext_c;
   logic signed [GAIN_W-1:0] stiff_s, damp_s;
   logic signed [KP_W-1:0]   kp_c;
   assign ext_c   = $signed({2'b00, dv_side.rest}) - $signed({1'b0, dv_len});
   assign stiff_s = $signed({1'b0, stiff_ff});
   assign damp_s  = $signed({1'b0, damp_ff});
   assign kp_c    = KP_W'(ext_c) * KP_W'(stiff_s);

   // P1: velocity projections per axis and the stiffness term.
   logic signed [PR_W-1:0] prx_ff, pry_ff;
   logic signed [KS_W-1:0] ks1_ff;
   logic signed [U_W-1:0]  ux1_ff, uy1_ff;
   logic                   c1_ff, p1_ff;

   // P2: projection sum.
   logic signed [PJ_W-1:0] pj_ff;
   logic signed [KS_W-1:0] ks2_ff;
   logic signed [U_W-1:0]  ux2_ff, uy2_ff;
   logic                   c2_ff, p2_ff;

   // P3: damping term.
   logic signed [DP_W-1:0] dp_c;
   logic signed [DS_W-1:0] ds_ff;
   logic signed [KS_W-1:0] ks3_ff;
   logic signed [U_W-1:0]  ux3_ff, uy3_ff;
   logic                   c3_ff, p3_ff;

   // P4: scalar force along the direction.
   logic signed [INR_W-1:0] inr_ff;
   logic signed [U_W-1:0]   ux4_ff, uy4_ff;
   logic                    c4_ff, p4_ff;

   // P5: force components before saturation.
   logic signed [FP_W-1:0] fxp_c, fyp_c;
   logic signed [FS_W-1:0] fx_ff, fy_ff;
   logic                   c5_ff, p5_ff;

   assign dp_c  = DP_W'(pj_ff) * DP_W'(damp_s);
   assign fxp_c = FP_W'(ux4_ff) * FP_W'(inr_ff);
   assign fyp_c = FP_W'(uy4_ff) * FP_W'(inr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= 1'b0;
         p2_ff <= 1'b0;
         p3_ff <= 1'b0;
         p4_ff <= 1'b0;
         p5_ff <= 1'b0;
      end else if (adv) begin
         p1_ff <= dv_vld;
         p2_ff <= p1_ff;
         p3_ff <= p2_ff;
         p4_ff <= p3_ff;
         p5_ff <= p4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prx_ff <= PR_W'(dv_side.rvx) * PR_W'(ux);
         pry_ff <= PR_W'(dv_side.rvy) * PR_W'(uy);
         ks1_ff <= KS_W'(kp_c >>> FRAC_BITS);
         ux1_ff <= ux;
         uy1_ff <= uy;
         c1_ff  <= dv_close;

         pj_ff  <= PJ_W'(prx_ff >>> FRAC_BITS) + PJ_W'(pry_ff >>> FRAC_BITS);
         ks2_ff <= ks1_ff;
         ux2_ff <= ux1_ff;
         uy2_ff <= uy1_ff;
         c2_ff  <= c1_ff;

         ds_ff  <= DS_W'(dp_c >>> FRAC_BITS);
         ks3_ff <= ks2_ff;
         ux3_ff <= ux2_ff;
         uy3_ff <= uy2_ff;
         c3_ff  <= c2_ff;

         inr_ff <= INR_W'(ks3_ff) - INR_W'(ds_ff);
         ux4_ff <= ux3_ff;
         uy4_ff <= uy3_ff;
         c4_ff  <= c3_ff;

         fx_ff  <= FS_W'(fxp_c >>> FRAC_BITS);
         fy_ff  <= FS_W'(fyp_c >>> FRAC_BITS);
         c5_ff  <= c4_ff;
      end
   end

   // Saturation into the result register. A spring that is too short gives
   // zero force and never reports clipping.
   localparam logic signed [FS_W-1:0] S32_MAX = FS_W'(64'sh7FFF_FFFF);
   localparam logic signed [FS_W-1:0] S32_MIN = -FS_W'(64'sh8000_0000);

   logic [IN_W-1:0] fx_sat, fy_sat;
   logic            clip_x, clip_y;

   always_comb begin
      clip_x = (fx_ff > S32_MAX) || (fx_ff < S32_MIN);
      clip_y = (fy_ff > S32_MAX) || (fy_ff < S32_MIN);
      fx_sat = fx_ff > S32_MAX ? IN_W'(S32_MAX) :
               fx_ff < S32_MIN ? IN_W'(S32_MIN) : fx_ff[IN_W-1:0];
      fy_sat = fy_ff > S32_MAX ? IN_W'(S32_MAX) :
               fy_ff < S32_MIN ? IN_W'(S32_MIN) : fy_ff[IN_W-1:0];
   end

   logic [63:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= p5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= c5_ff ? '0 : {fy_sat, fx_sat};
         rsp_user_ff <= {!c5_ff && (clip_x || clip_y), c5_ff};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== rtl/dsf_checker.sv =====
// Port-level checks of the damped spring force block and the bind that
// attaches them to damped_spring_force_2d. No package dependencies.
module dsf_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [287:0] req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [63:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         csr_we,
   input logic [1:0]   csr_addr,
   input logic [31:0]  csr_wdata
);

   // A too-short spring gives zero force and no clipping.
   a_close_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 64'd0 && !rsp_tuser[1])
      else $error("too_close result carries force");

   // Clipping leaves at least one component at a rail.
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |->
         rsp_tdata[31:0] == 32'h7FFF_FFFF || rsp_tdata[31:0] == 32'h8000_0000 ||
         rsp_tdata[63:32] == 32'h7FFF_FFFF || rsp_tdata[63:32] == 32'h8000_0000)
      else $error("saturated flag without a clipped component");

   // An empty result register never blocks the input.
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // A held result keeps its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Nothing is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind damped_spring_force_2d dsf_checker u_dsf_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for damped_spring_force_2d: drives springs, predicts
// each force in a behavioral model and checks results in order. Uses dsf_pkg.
`timescale 1ns / 100ps

module tb_top;
   import dsf_pkg::*;

   // Result latency of damped_spring_force_2d, used for the idle pauses.
   localparam int PIPE_LAT = 58;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [287:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_addr = '0;
   logic [31:0]  csr_wdata = '0;

   typedef struct {
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic               close;
      logic               clip;
   } force_type;

   force_type pending_forces[$];
   int        error_count = 0;
   int        sent_count = 0;

   // Configuration copy held by the predictor.
   logic [31:0] k_gain = 32'd65536;
   logic [31:0] c_gain = 32'd0;
   logic [15:0] d_min  = 16'd1;

   always #2 clock = ~clock;

   damped_spring_force_2d uut (.*);

   // Product of two fixed-point values, shifted right rounding toward minus
   // infinity. An arithmetic shift of the exact product does exactly that.
   function automatic logic signed [127:0] fx_mul(logic signed [127:0] a,
                                                  logic signed [127:0] b);
      logic signed [127:0] p;
      p = a * b;
      return p >>> FRAC_BITS;
   endfunction

   function automatic logic [63:0] root_floor(logic [127:0] v);
      logic [63:0]  r;
      logic [63:0]  t;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if ({64'd0, t} * {64'd0, t} <= v) r = t;
      end
      return r;
   endfunction

   function automatic force_type spring_force(logic [287:0] d);
      logic signed [127:0] dx, dy, rvx, rvy, ux, uy, proj, ext, inner, fxw, fyw;
      logic [127:0]        mx, my, len;
      force_type           f;
      dx  = $signed(d[31:0])    - $signed(d[159:128]);
      dy  = $signed(d[63:32])   - $signed(d[191:160]);
      rvx = $signed(d[95:64])   - $signed(d[223:192]);
      rvy = $signed(d[127:96])  - $signed(d[255:224]);
      mx  = dx < 0 ? -dx : dx;
      my  = dy < 0 ? -dy : dy;
      len = 128'(root_floor(mx * mx + my * my));
      f.close = 1'b0;
      f.clip  = 1'b0;
      f.fx    = '0;
      f.fy    = '0;
      if (len <= {112'd0, d_min}) begin
         f.close = 1'b1;
         return f;
      end
      ux = $signed((mx << FRAC_BITS) / len);
      uy = $signed((my << FRAC_BITS) / len);
      if (dx < 0) ux = -ux;
      if (dy < 0) uy = -uy;
      proj  = fx_mul(rvx, ux) + fx_mul(rvy, uy);
      ext   = $signed({96'd0, d[287:256]}) - $signed(len);
      inner = fx_mul(ext, $signed({96'd0, k_gain}))
            - fx_mul(proj, $signed({96'd0, c_gain}));
      fxw = fx_mul(ux, inner);
      fyw = fx_mul(uy, inner);
      if (fxw > 128'sd2147483647) begin f.fx = 32'h7FFFFFFF; f.clip = 1; end
      else if (fxw < -128'sd2147483648) begin f.fx = 32'h80000000; f.clip = 1; end
      else f.fx = fxw[31:0];
      if (fyw > 128'sd2147483647) begin f.fy = 32'h7FFFFFFF; f.clip = 1; end
      else if (fyw < -128'sd2147483648) begin f.fy = 32'h80000000; f.clip = 1; end
      else f.fy = fyw[31:0];
      return f;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h, want %h", what, got, want);
      error_count++;
   endtask

   // Sender: one transfer per call; bursts of random length with random gaps.
   int burst_left = 0;

   task automatic send_spring(logic [287:0] d);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      pending_forces.push_back(spring_force(d));
      sent_count++;
      burst_left--;
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
   endtask

   // Receiver stall pattern: alternates calm stretches and choppy stretches.
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (reset) rsp_tready <= 1'b0;
      else if (stall_phase[8]) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   // Result checker: every result transfer is compared with the oldest prediction.
   always @(posedge clock) begin
      force_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_forces.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata[31:0], '0);
         end else begin
            w = pending_forces.pop_front();
            if (rsp_tdata[31:0] !== w.fx) report_mismatch("force_x", rsp_tdata[31:0], w.fx);
            if (rsp_tdata[63:32] !== w.fy) report_mismatch("force_y", rsp_tdata[63:32], w.fy);
            if (rsp_tuser[0] !== w.close)
               report_mismatch("too_close", 32'(rsp_tuser[0]), 32'(w.close));
            if (rsp_tuser[1] !== w.clip)
               report_mismatch("saturated", 32'(rsp_tuser[1]), 32'(w.clip));
         end
      end
   end

   // Waits until every predicted result has arrived, then lets the pipe settle.
   task automatic drain();
      end_burst();
      while (pending_forces.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
   endtask

   // One register write, then the write port goes idle and the predictor copy is updated.
   task automatic write_reg(csr_index_type idx, logic [31:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_STIFFNESS:    k_gain = val;
         CSR_DAMPING_GAIN: c_gain = val;
         CSR_MIN_DISTANCE: d_min  = val[15:0];
         default: ;
      endcase
   endtask

   function automatic logic [287:0] pack_spring(logic [31:0] ax, ay, vax, vay,
                                                bx, by, vbx, vby, rest);
      return {rest, vby, vbx, by, bx, vay, vax, ay, ax};
   endfunction

   function automatic logic [31:0] rnd_coord();
      // Mostly moderate positions so that forces stay in range, some wide.
      case ($urandom_range(0, 5))
         0:       return $urandom();
         1:       return $urandom_range(0, 7) - 4;
         default: return $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh007FFFFF;
      endcase
   endfunction

   function automatic logic [287:0] rnd_spring();
      logic [31:0] ax, ay;
      ax = rnd_coord();
      ay = rnd_coord();
      // Now and then B sits right next to A to hit the minimum distance.
      if ($urandom_range(0, 9) == 0)
         return pack_spring(ax, ay, rnd_coord(), rnd_coord(),
                            ax + $urandom_range(0, 4) - 2, ay + $urandom_range(0, 4) - 2,
                            rnd_coord(), rnd_coord(), $urandom_range(0, 32'h00FFFFFF));
      return pack_spring(ax, ay, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                         rnd_coord(), rnd_coord(),
                         $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h00FFFFFF));
   endfunction

   // Extremes of every field, coincident points, axis-aligned springs.
   task automatic test_directed();
      send_spring(pack_spring(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_spring(pack_spring(1, 0, 0, 0, 0, 0, 0, 0, 0));
      send_spring(pack_spring(2, 0, 0, 0, 0, 0, 0, 0, 0));
      send_spring(pack_spring(32'h10000, 0, 0, 0, 0, 0, 0, 0, 32'h20000));
      send_spring(pack_spring(0, 32'h30000, 32'h10000, 0, 0, 0, 0, 32'hFFFF0000, 32'h10000));
      send_spring(pack_spring(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                              32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                              32'hFFFFFFFF));
      send_spring(pack_spring(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0));
      send_spring(pack_spring(32'h80000000, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 32'hFFFFFFFF));
      send_spring(pack_spring(0, 32'h7FFFFFFF, 0, 0, 0, 32'h80000000, 0, 0, 0));
      send_spring(pack_spring(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA,
                              0, 0, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA));
      send_spring(pack_spring(32'h12345678, 32'hFEDCBA98, 32'h01000000, 32'hFF000000,
                              32'h00010000, 32'h00020000, 0, 0, 32'h55555555));
      drain();
   endtask

   task automatic test_random(int n);
      repeat (n) send_spring(rnd_spring());
      drain();
   endtask

   // Each phase uses one setting of the registers, extremes included.
   task automatic test_settings();
      write_reg(CSR_STIFFNESS, 32'hFFFFFFFF);
      write_reg(CSR_DAMPING_GAIN, 32'hFFFFFFFF);
      write_reg(CSR_MIN_DISTANCE, 32'h0000FFFF);
      test_directed();
      test_random(285);
      write_reg(CSR_STIFFNESS, 32'd0);
      write_reg(CSR_DAMPING_GAIN, 32'h00008000);
      write_reg(CSR_MIN_DISTANCE, 32'd0);
      test_directed();
      test_random(285);
      for (int i = 0; i < 3; i++) begin
         write_reg(CSR_STIFFNESS, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h40000));
         write_reg(CSR_DAMPING_GAIN, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h40000));
         write_reg(CSR_MIN_DISTANCE, $urandom());
         test_random(285);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(285);
      test_settings();
      if (error_count == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_top: done, errors");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/dsf_pkg.sv
rtl/dsf_sqrt.sv
rtl/dsf_div.sv
rtl/damped_spring_force_2d.sv
rtl/dsf_checker.sv
tb/tb_top.sv
